>>> src/cscr_pkg.sv
// Shared types, field widths, codes and reset values for the clap and schedule relay controller.
// No dependencies; every other file in src imports this package.
package cscr_pkg;

  localparam int unsigned LEVEL_W  = 12;
  localparam int unsigned MS_W     = 32;
  localparam int unsigned HOLD_W   = 8;
  localparam int unsigned COOL_W   = 11;
  localparam int unsigned MIN_W    = 11;
  localparam int unsigned HOUR_W   = 5;
  localparam int unsigned MINUTE_W = 6;
  localparam int unsigned DAY_W    = 9;
  localparam int unsigned OP_W     = 2;
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned CNT_W    = 32;

  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_ADDR_W = 5;
  localparam int unsigned REG_IDX_W  = 3;

  // Operation codes
  localparam logic [OP_W-1:0] OP_SOUND    = 2'd0;
  localparam logic [OP_W-1:0] OP_SCHEDULE = 2'd1;
  localparam logic [OP_W-1:0] OP_RELAY    = 2'd2;

  // Relay command codes
  localparam logic [CMD_W-1:0] CMD_OFF    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ON     = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TOGGLE = 2'd2;

  // Register indexes
  localparam logic [REG_IDX_W-1:0] REG_THRESHOLD = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_MIN_HOLD  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_COOLDOWN  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_CLAP_EN   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_SCHED_EN  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_ON_TIME   = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_OFF_TIME  = 3'd6;

  // Reset values and write limits
  localparam logic [LEVEL_W-1:0] THRESHOLD_RST = 12'd1800;
  localparam logic [LEVEL_W-1:0] THRESHOLD_LO  = 12'd50;
  localparam logic [HOLD_W-1:0]  HOLD_RST      = 8'd5;
  localparam logic [HOLD_W-1:0]  HOLD_LO       = 8'd5;
  localparam logic [HOLD_W-1:0]  HOLD_HI       = 8'd250;
  localparam logic [COOL_W-1:0]  COOL_RST      = 11'd650;
  localparam logic [COOL_W-1:0]  COOL_LO       = 11'd200;
  localparam logic [COOL_W-1:0]  COOL_HI       = 11'd2000;
  localparam logic [MIN_W-1:0]   ON_TIME_RST   = 11'd1080;
  localparam logic [MIN_W-1:0]   OFF_TIME_RST  = 11'd360;
  localparam logic [MIN_W-1:0]   TIME_HI       = 11'd1439;
  localparam logic [HOUR_W-1:0]  HOUR_MAX      = 5'd23;
  localparam logic [MINUTE_W-1:0] MINUTE_MAX   = 6'd59;

  typedef struct packed {
    logic [OP_W-1:0]     operation;
    logic [LEVEL_W-1:0]  sound_level;
    logic [MS_W-1:0]     now_ms;
    logic [HOUR_W-1:0]   clock_hour;
    logic [MINUTE_W-1:0] clock_minute;
    logic [DAY_W-1:0]    day_of_year;
    logic                clock_valid;
    logic [CMD_W-1:0]    relay_command;
  } in_item_t;

  typedef struct packed {
    logic               relay_on;
    logic               sound_active;
    logic [LEVEL_W-1:0] peak_level;
    logic [CNT_W-1:0]   clap_count;
    logic               clap_triggered;
  } out_item_t;

  // Register values plus the one-cycle side effects of a write
  typedef struct packed {
    logic [LEVEL_W-1:0] threshold;
    logic [HOLD_W-1:0]  min_hold;
    logic [COOL_W-1:0]  cooldown;
    logic               clap_en;
    logic               sched_en;
    logic [MIN_W-1:0]   on_time;
    logic [MIN_W-1:0]   off_time;
    logic               rearm;
    logic               throttle_clr;
  } cfg_t;

  // Clock matches a minute of day; out-of-range hour or minute never matches
  function automatic logic time_match(input logic [HOUR_W-1:0] hour,
                                      input logic [MINUTE_W-1:0] minute,
                                      input logic [MIN_W-1:0] at);
    logic [MIN_W-1:0] hm;
    hm = ({6'd0, hour} << 6) - ({6'd0, hour} << 2) + {5'd0, minute};
    return (hour <= HOUR_MAX) && (minute <= MINUTE_MAX) && (hm == at);
  endfunction

endpackage

>>> src/cscr_if.sv
// Valid/ready channel interfaces for input items and result items.
// Depends on cscr_pkg for field widths.
interface cscr_in_if;
  import cscr_pkg::*;
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     operation;
  logic [LEVEL_W-1:0]  sound_level;
  logic [MS_W-1:0]     now_ms;
  logic [HOUR_W-1:0]   clock_hour;
  logic [MINUTE_W-1:0] clock_minute;
  logic [DAY_W-1:0]    day_of_year;
  logic                clock_valid;
  logic [CMD_W-1:0]    relay_command;

  modport source (output valid, operation, sound_level, now_ms, clock_hour, clock_minute,
                  day_of_year, clock_valid, relay_command, input ready);
  modport sink (input valid, operation, sound_level, now_ms, clock_hour, clock_minute,
                day_of_year, clock_valid, relay_command, output ready);
endinterface

interface cscr_out_if;
  import cscr_pkg::*;
  logic               valid;
  logic               ready;
  logic               relay_on;
  logic               sound_active;
  logic [LEVEL_W-1:0] peak_level;
  logic [CNT_W-1:0]   clap_count;
  logic               clap_triggered;

  modport source (output valid, relay_on, sound_active, peak_level, clap_count,
                  clap_triggered, input ready);
  modport sink (input valid, relay_on, sound_active, peak_level, clap_count,
                clap_triggered, output ready);
endinterface

>>> src/cscr_cfg.sv
// APB-style configuration register file with saturating writes and read-back.
// Depends on cscr_pkg.
module cscr_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [cscr_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [cscr_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [cscr_pkg::CFG_DATA_W-1:0] prdata,
  output cscr_pkg::cfg_t                  cfg
);
  import cscr_pkg::*;

  logic [LEVEL_W-1:0] threshold_r, threshold_nxt;
  logic [HOLD_W-1:0]  min_hold_r, min_hold_nxt;
  logic [COOL_W-1:0]  cooldown_r, cooldown_nxt;
  logic               clap_en_r, clap_en_nxt;
  logic               sched_en_r, sched_en_nxt;
  logic [MIN_W-1:0]   on_time_r, on_time_nxt;
  logic [MIN_W-1:0]   off_time_r, off_time_nxt;
  logic               rearm, throttle_clr;

  logic                 wr_en;
  logic [REG_IDX_W-1:0] idx;
  logic [LEVEL_W-1:0]   thr_w;
  logic [HOLD_W-1:0]    hold_w;
  logic [COOL_W-1:0]    cool_w;
  logic [MIN_W-1:0]     time_w;
  logic [LEVEL_W-1:0]   thr_sat;
  logic [HOLD_W-1:0]    hold_sat;
  logic [COOL_W-1:0]    cool_sat;
  logic [MIN_W-1:0]     time_sat;

  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[CFG_ADDR_W-1:2];
  assign thr_w  = pwdata[LEVEL_W-1:0];
  assign hold_w = pwdata[HOLD_W-1:0];
  assign cool_w = pwdata[COOL_W-1:0];
  assign time_w = pwdata[MIN_W-1:0];

  // Clamp write data into each register's legal range
  assign thr_sat  = (thr_w < THRESHOLD_LO) ? THRESHOLD_LO : thr_w;
  assign hold_sat = (hold_w < HOLD_LO) ? HOLD_LO : ((hold_w > HOLD_HI) ? HOLD_HI : hold_w);
  assign cool_sat = (cool_w < COOL_LO) ? COOL_LO : ((cool_w > COOL_HI) ? COOL_HI : cool_w);
  assign time_sat = (time_w > TIME_HI) ? TIME_HI : time_w;

  always_comb begin
    threshold_nxt = threshold_r;
    min_hold_nxt  = min_hold_r;
    cooldown_nxt  = cooldown_r;
    clap_en_nxt   = clap_en_r;
    sched_en_nxt  = sched_en_r;
    on_time_nxt   = on_time_r;
    off_time_nxt  = off_time_r;
    rearm         = 1'b0;
    throttle_clr  = 1'b0;
    if (wr_en) begin
      unique case (idx)
        REG_THRESHOLD: threshold_nxt = thr_sat;
        REG_MIN_HOLD:  min_hold_nxt = hold_sat;
        REG_COOLDOWN:  cooldown_nxt = cool_sat;
        REG_CLAP_EN: begin
          clap_en_nxt = pwdata[0];
          rearm       = 1'b1;
        end
        REG_SCHED_EN:  sched_en_nxt = pwdata[0];
        REG_ON_TIME: begin
          on_time_nxt  = time_sat;
          throttle_clr = 1'b1;
        end
        REG_OFF_TIME: begin
          off_time_nxt = time_sat;
          throttle_clr = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= THRESHOLD_RST;
      min_hold_r  <= HOLD_RST;
      cooldown_r  <= COOL_RST;
      clap_en_r   <= 1'b1;
      sched_en_r  <= 1'b0;
      on_time_r   <= ON_TIME_RST;
      off_time_r  <= OFF_TIME_RST;
    end else begin
      threshold_r <= threshold_nxt;
      min_hold_r  <= min_hold_nxt;
      cooldown_r  <= cooldown_nxt;
      clap_en_r   <= clap_en_nxt;
      sched_en_r  <= sched_en_nxt;
      on_time_r   <= on_time_nxt;
      off_time_r  <= off_time_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_THRESHOLD: prdata = {{(CFG_DATA_W-LEVEL_W){1'b0}}, threshold_r};
      REG_MIN_HOLD:  prdata = {{(CFG_DATA_W-HOLD_W){1'b0}}, min_hold_r};
      REG_COOLDOWN:  prdata = {{(CFG_DATA_W-COOL_W){1'b0}}, cooldown_r};
      REG_CLAP_EN:   prdata = {{(CFG_DATA_W-1){1'b0}}, clap_en_r};
      REG_SCHED_EN:  prdata = {{(CFG_DATA_W-1){1'b0}}, sched_en_r};
      REG_ON_TIME:   prdata = {{(CFG_DATA_W-MIN_W){1'b0}}, on_time_r};
      REG_OFF_TIME:  prdata = {{(CFG_DATA_W-MIN_W){1'b0}}, off_time_r};
      default:       prdata = '0;
    endcase
  end

  assign cfg = '{threshold: threshold_r, min_hold: min_hold_r, cooldown: cooldown_r,
                 clap_en: clap_en_r, sched_en: sched_en_r, on_time: on_time_r,
                 off_time: off_time_r, rearm: rearm, throttle_clr: throttle_clr};

endmodule

>>> src/cscr_step.sv
// Controller state and the single-pass update logic for one item.
// Depends on cscr_pkg; fed by the input register and cscr_cfg in the top level.
module cscr_step (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 fire,
  input  cscr_pkg::in_item_t   item,
  input  cscr_pkg::cfg_t       cfg,
  output cscr_pkg::out_item_t  result
);
  import cscr_pkg::*;

  logic               relay_r, relay_nxt;
  logic [LEVEL_W-1:0] level_r, level_nxt;
  logic [LEVEL_W-1:0] peak_r, peak_nxt;
  logic               prev_active_r, prev_active_nxt;
  logic               armed_r, armed_nxt;
  logic [MS_W-1:0]    since_r, since_nxt;
  logic [MS_W-1:0]    last_clap_r, last_clap_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               tvalid_r, tvalid_nxt;
  logic [DAY_W-1:0]   tday_r, tday_nxt;
  logic [MINUTE_W-1:0] tmin_r, tmin_nxt;

  logic            active;
  logic            rising;
  logic [MS_W-1:0] since_eff;
  logic [MS_W-1:0] hold_dt;
  logic [MS_W-1:0] cool_dt;
  logic            clap;
  logic            sched_ok;
  logic            want_on, want_off;

  assign active    = item.sound_level >= cfg.threshold;
  assign rising    = active && !prev_active_r;
  assign since_eff = rising ? item.now_ms : since_r;
  assign hold_dt   = item.now_ms - since_eff;
  assign cool_dt   = item.now_ms - last_clap_r;

  assign sched_ok = cfg.sched_en && item.clock_valid &&
                    !(tvalid_r && item.day_of_year == tday_r && item.clock_minute == tmin_r);
  assign want_on  = time_match(item.clock_hour, item.clock_minute, cfg.on_time);
  assign want_off = time_match(item.clock_hour, item.clock_minute, cfg.off_time);

  always_comb begin
    relay_nxt       = relay_r;
    level_nxt       = level_r;
    peak_nxt        = peak_r;
    prev_active_nxt = prev_active_r;
    armed_nxt       = armed_r;
    since_nxt       = since_r;
    last_clap_nxt   = last_clap_r;
    count_nxt       = count_r;
    tvalid_nxt      = tvalid_r;
    tday_nxt        = tday_r;
    tmin_nxt        = tmin_r;
    clap            = 1'b0;

    unique case (item.operation)
      OP_SOUND: begin
        level_nxt = item.sound_level;
        if (item.sound_level > peak_r) begin
          peak_nxt = item.sound_level;
        end else if (peak_r != '0) begin
          peak_nxt = peak_r - 1'b1;
        end
        since_nxt       = since_eff;
        prev_active_nxt = active;
        if (!active) begin
          armed_nxt = 1'b1;
        end else if (cfg.clap_en && armed_r &&
                     hold_dt >= {{(MS_W-HOLD_W){1'b0}}, cfg.min_hold} &&
                     cool_dt >= {{(MS_W-COOL_W){1'b0}}, cfg.cooldown}) begin
          relay_nxt     = !relay_r;
          count_nxt     = count_r + 1'b1;
          last_clap_nxt = item.now_ms;
          armed_nxt     = 1'b0;
          clap          = 1'b1;
        end
      end
      OP_SCHEDULE: begin
        if (sched_ok) begin
          if ((want_on && !relay_r) || (!(want_on && !relay_r) && want_off && relay_r)) begin
            relay_nxt  = want_on && !relay_r;
            tvalid_nxt = 1'b1;
            tday_nxt   = item.day_of_year;
            tmin_nxt   = item.clock_minute;
          end
        end
      end
      OP_RELAY: begin
        case (item.relay_command)
          CMD_OFF:    relay_nxt = 1'b0;
          CMD_ON:     relay_nxt = 1'b1;
          CMD_TOGGLE: relay_nxt = !relay_r;
          default:    relay_nxt = relay_r;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      relay_r       <= 1'b0;
      level_r       <= '0;
      peak_r        <= '0;
      prev_active_r <= 1'b0;
      armed_r       <= 1'b1;
      since_r       <= '0;
      last_clap_r   <= '0;
      count_r       <= '0;
      tvalid_r      <= 1'b0;
      tday_r        <= '0;
      tmin_r        <= '0;
    end else if (fire) begin
      relay_r       <= relay_nxt;
      level_r       <= level_nxt;
      peak_r        <= peak_nxt;
      prev_active_r <= prev_active_nxt;
      armed_r       <= armed_nxt;
      since_r       <= since_nxt;
      last_clap_r   <= last_clap_nxt;
      count_r       <= count_nxt;
      tvalid_r      <= tvalid_nxt;
      tday_r        <= tday_nxt;
      tmin_r        <= tmin_nxt;
    end else begin
      // Config effects; writes must land while no item is in flight, unchecked
      if (cfg.rearm) begin
        armed_r <= 1'b1;
      end
      if (cfg.throttle_clr) begin
        tvalid_r <= 1'b0;
      end
    end
  end

  assign result = '{relay_on: relay_nxt,
                    sound_active: (level_nxt >= cfg.threshold),
                    peak_level: peak_nxt,
                    clap_count: count_nxt,
                    clap_triggered: clap};

endmodule

>>> src/clap_and_schedule_relay_control_core.sv
// Top level of the clap and schedule relay controller: input register, result register,
// configuration port. Depends on cscr_pkg, cscr_if, cscr_cfg and cscr_step.
//
// Each accepted item yields exactly one result: it waits in the input register, where
// the state update and status are computed in a single pass, until the result register is
// free, then moves there. A new item is accepted every cycle as long as
// the result side keeps taking results; the input and result registers decouple the two
// handshakes, so a stalled consumer only holds the input once both stages are full.
// Configuration registers sit at byte address 4*index and may be written only while the
// block holds no item.
module clap_and_schedule_relay_control_core (
  input  logic                            clk,
  input  logic                            rst_n,
  cscr_in_if.sink                         in_ch,
  cscr_out_if.source                      out_ch,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [cscr_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [cscr_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [cscr_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                            cfg_pready
);
  import cscr_pkg::*;

  logic      in_valid_r;
  in_item_t  in_item_r;
  logic      out_valid_r;
  out_item_t out_item_r;
  logic      advance;
  out_item_t result;
  cfg_t      cfg;

  assign cfg_pready = 1'b1;

  cscr_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  // Advance the held item once the result register is free or being drained
  assign advance     = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_item_r <= '{operation: in_ch.operation, sound_level: in_ch.sound_level,
                     now_ms: in_ch.now_ms, clock_hour: in_ch.clock_hour,
                     clock_minute: in_ch.clock_minute, day_of_year: in_ch.day_of_year,
                     clock_valid: in_ch.clock_valid, relay_command: in_ch.relay_command};
    end
  end

  cscr_step u_step (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (advance),
    .item   (in_item_r),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item_r <= result;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.relay_on       = out_item_r.relay_on;
  assign out_ch.sound_active   = out_item_r.sound_active;
  assign out_ch.peak_level     = out_item_r.peak_level;
  assign out_ch.clap_count     = out_item_r.clap_count;
  assign out_ch.clap_triggered = out_item_r.clap_triggered;

endmodule

>>> dv/tb_clap_and_schedule_relay_control_core.sv
// Self-checking testbench for clap_and_schedule_relay_control_core: directed table, then
// random phases under changing settings; statuses checked against a predictor or table.
// Depends on cscr_pkg, cscr_if and the RTL under src.
`timescale 1ns / 100ps

module tb_clap_and_schedule_relay_control_core;
  import cscr_pkg::*;

  localparam logic [OP_W-1:0]      OP_SPARE    = 2'd3;
  localparam logic [CMD_W-1:0]     CMD_SPARE   = 2'd3;
  localparam logic [REG_IDX_W-1:0] REG_SPARE   = 3'd7;
  localparam logic [LEVEL_W-1:0]   LEVEL_MAX   = '1;
  localparam int unsigned          CYCLE_LIMIT = 400000;
  localparam int unsigned          PHASES      = 19;
  localparam int unsigned          PHASE_ITEMS = 100;

  typedef struct {
    bit                    is_write;
    logic [REG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_data;
    in_item_t              item;
    bit                    typed;
    out_item_t             want;
  } plan_row_t;

  logic clk;
  logic rst_n;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  cscr_in_if  in_bus ();
  cscr_out_if out_bus ();

  clap_and_schedule_relay_control_core u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_bus),
    .out_ch      (out_bus),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // Register copy
  logic [LEVEL_W-1:0] thr;
  logic [HOLD_W-1:0]  hold_ms;
  logic [COOL_W-1:0]  cool_ms;
  logic               clap_on;
  logic               sched_on;
  logic [MIN_W-1:0]   on_min;
  logic [MIN_W-1:0]   off_min;

  // Controller state copy
  logic               relay;
  logic [LEVEL_W-1:0] level_now;
  logic [LEVEL_W-1:0] peak;
  logic               was_active;
  logic               armed;
  logic [MS_W-1:0]    since_ms;
  logic [MS_W-1:0]    last_clap_ms;
  logic [CNT_W-1:0]   claps;
  logic               throttle_set;
  logic [DAY_W-1:0]   throttle_day;
  logic [MINUTE_W-1:0] throttle_min;

  out_item_t   status_due[$];
  plan_row_t   plan[$];
  int unsigned fails;
  int unsigned cycle_count;
  bit          steady;
  logic [MS_W-1:0] clock_ms;
  bit          in_burst;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic int unsigned clamp(input int unsigned v, input int unsigned lo,
                                        input int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic bit minute_hits(input logic [HOUR_W-1:0] h, input logic [MINUTE_W-1:0] m,
                                     input logic [MIN_W-1:0] at);
    int unsigned tod;
    tod = int'(h) * 60 + int'(m);
    return (h <= HOUR_MAX) && (m <= MINUTE_MAX) && (tod == int'(at));
  endfunction

  function automatic void reset_model();
    thr          = THRESHOLD_RST;
    hold_ms      = HOLD_RST;
    cool_ms      = COOL_RST;
    clap_on      = 1'b1;
    sched_on     = 1'b0;
    on_min       = ON_TIME_RST;
    off_min      = OFF_TIME_RST;
    relay        = 1'b0;
    level_now    = '0;
    peak         = '0;
    was_active   = 1'b0;
    armed        = 1'b1;
    since_ms     = '0;
    last_clap_ms = '0;
    claps        = '0;
    throttle_set = 1'b0;
    throttle_day = '0;
    throttle_min = '0;
  endfunction

  function automatic void apply_reg(input logic [REG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_THRESHOLD: thr = LEVEL_W'(clamp(32'(data[LEVEL_W-1:0]), 32'(THRESHOLD_LO),
                                          32'(LEVEL_MAX)));
      REG_MIN_HOLD:  hold_ms = HOLD_W'(clamp(32'(data[HOLD_W-1:0]), 32'(HOLD_LO),
                                             32'(HOLD_HI)));
      REG_COOLDOWN:  cool_ms = COOL_W'(clamp(32'(data[COOL_W-1:0]), 32'(COOL_LO),
                                             32'(COOL_HI)));
      REG_CLAP_EN: begin
        clap_on = data[0];
        armed   = 1'b1;
      end
      REG_SCHED_EN:  sched_on = data[0];
      REG_ON_TIME: begin
        on_min       = MIN_W'(clamp(32'(data[MIN_W-1:0]), 0, 32'(TIME_HI)));
        throttle_set = 1'b0;
      end
      REG_OFF_TIME: begin
        off_min      = MIN_W'(clamp(32'(data[MIN_W-1:0]), 0, 32'(TIME_HI)));
        throttle_set = 1'b0;
      end
      default: ;
    endcase
  endfunction

  // Advance the state copy by one item and return the status it reports
  function automatic out_item_t relay_next(input in_item_t it);
    out_item_t       res;
    logic            act;
    logic            fired;
    logic            want_on;
    logic            want_off;
    logic [MS_W-1:0] held;
    logic [MS_W-1:0] quiet;
    fired = 1'b0;
    case (it.operation)
      OP_SOUND: begin
        level_now = it.sound_level;
        if (it.sound_level > peak) peak = it.sound_level;
        else if (peak != '0) peak = peak - LEVEL_W'(1);
        act = (it.sound_level >= thr);
        if (act && !was_active) since_ms = it.now_ms;
        was_active = act;
        held  = it.now_ms - since_ms;
        quiet = it.now_ms - last_clap_ms;
        if (!act) begin
          armed = 1'b1;
        end else if (clap_on && armed && held >= MS_W'(hold_ms) && quiet >= MS_W'(cool_ms)) begin
          relay        = !relay;
          claps        = claps + CNT_W'(1);
          last_clap_ms = it.now_ms;
          armed        = 1'b0;
          fired        = 1'b1;
        end
      end
      OP_SCHEDULE: begin
        if (sched_on && it.clock_valid &&
            !(throttle_set && it.day_of_year == throttle_day &&
              it.clock_minute == throttle_min)) begin
          want_on  = minute_hits(it.clock_hour, it.clock_minute, on_min);
          want_off = minute_hits(it.clock_hour, it.clock_minute, off_min);
          if ((want_on && !relay) || (!(want_on && !relay) && want_off && relay)) begin
            relay        = want_on && !relay;
            throttle_set = 1'b1;
            throttle_day = it.day_of_year;
            throttle_min = it.clock_minute;
          end
        end
      end
      OP_RELAY: begin
        case (it.relay_command)
          CMD_OFF:    relay = 1'b0;
          CMD_ON:     relay = 1'b1;
          CMD_TOGGLE: relay = !relay;
          default: ;
        endcase
      end
      default: ;
    endcase
    res.relay_on       = relay;
    res.sound_active   = (level_now >= thr);
    res.peak_level     = peak;
    res.clap_count     = claps;
    res.clap_triggered = fired;
    return res;
  endfunction

  function automatic in_item_t noise_item();
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    return raw[$bits(in_item_t)-1:0];
  endfunction

  function automatic plan_row_t blank_row();
    plan_row_t r;
    r.is_write = 1'b0;
    r.reg_idx  = '0;
    r.reg_data = '0;
    r.item     = noise_item();
    r.typed    = 1'b0;
    r.want     = '0;
    return r;
  endfunction

  function automatic plan_row_t sound_row(input logic [LEVEL_W-1:0] lvl,
                                          input logic [MS_W-1:0] ms);
    plan_row_t r;
    r = blank_row();
    r.item.operation   = OP_SOUND;
    r.item.sound_level = lvl;
    r.item.now_ms      = ms;
    return r;
  endfunction

  function automatic plan_row_t sched_row(input logic [HOUR_W-1:0] h,
                                          input logic [MINUTE_W-1:0] m,
                                          input logic [DAY_W-1:0] d, input logic v);
    plan_row_t r;
    r = blank_row();
    r.item.operation    = OP_SCHEDULE;
    r.item.clock_hour   = h;
    r.item.clock_minute = m;
    r.item.day_of_year  = d;
    r.item.clock_valid  = v;
    return r;
  endfunction

  function automatic plan_row_t op_row(input logic [OP_W-1:0] op,
                                       input logic [CMD_W-1:0] c);
    plan_row_t r;
    r = blank_row();
    r.item.operation     = op;
    r.item.relay_command = c;
    return r;
  endfunction

  function automatic plan_row_t write_row(input logic [REG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] data);
    plan_row_t r;
    r = blank_row();
    r.is_write = 1'b1;
    r.reg_idx  = idx;
    r.reg_data = data;
    return r;
  endfunction

  function automatic plan_row_t known(input plan_row_t r, input logic on, input logic act,
                                      input logic [LEVEL_W-1:0] pk, input logic [CNT_W-1:0] cnt,
                                      input logic trig);
    plan_row_t k;
    k = r;
    k.typed = 1'b1;
    k.want  = '{relay_on: on, sound_active: act, peak_level: pk, clap_count: cnt,
                clap_triggered: trig};
    return k;
  endfunction

  function automatic int unsigned idle_len();
    if (steady) return 0;
    return $urandom_range(0, 8);
  endfunction

  // Mostly well-formed traffic: sound bursts on a rising clock, schedule hits at the
  // configured minutes on a few days, plus relay commands and noise
  function automatic in_item_t rand_item();
    in_item_t         it;
    int unsigned      pick;
    int unsigned      sel;
    logic [MIN_W-1:0] at;
    it   = noise_item();
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      it.operation = OP_SOUND;
      if ($urandom_range(0, 99) == 0) clock_ms = $urandom;
      else if ($urandom_range(0, 3) == 0) clock_ms = clock_ms + MS_W'($urandom_range(0, 700));
      else clock_ms = clock_ms + MS_W'($urandom_range(0, 30));
      it.now_ms = clock_ms;
      if ($urandom_range(0, 7) == 0) in_burst = !in_burst;
      if ($urandom_range(0, 9) == 0) it.sound_level = LEVEL_W'($urandom);
      else if (in_burst) it.sound_level = LEVEL_W'($urandom_range(32'(thr), 32'(LEVEL_MAX)));
      else it.sound_level = LEVEL_W'($urandom_range(0, 32'(thr) - 1));
    end else if (pick < 85) begin
      it.operation   = OP_SCHEDULE;
      it.clock_valid = ($urandom_range(0, 9) != 0);
      sel = $urandom_range(0, 3);
      if (sel < 2) begin
        at = (sel == 0) ? on_min : off_min;
        it.clock_hour   = HOUR_W'(at / 60);
        it.clock_minute = MINUTE_W'(at % 60);
      end else if (sel == 2) begin
        it.clock_hour   = HOUR_W'($urandom_range(0, 23));
        it.clock_minute = MINUTE_W'($urandom_range(0, 59));
      end
      if (sel != 3) it.day_of_year = DAY_W'($urandom_range(0, 3));
    end else if (pick < 97) begin
      it.operation = OP_RELAY;
    end else begin
      it.operation = OP_SPARE;
    end
    return it;
  endfunction

  // mode 0 drives every register to its floor, mode 1 to its ceiling
  function automatic logic [CFG_DATA_W-1:0] cfg_pick(input logic [REG_IDX_W-1:0] idx,
                                                     input int unsigned mode);
    if (mode == 0) return '0;
    if (mode == 1) return '1;
    case (idx)
      REG_THRESHOLD: return ($urandom_range(0, 1) != 0) ? $urandom_range(50, 3000) : $urandom;
      REG_MIN_HOLD:  return ($urandom_range(0, 1) != 0) ? $urandom_range(5, 60) : $urandom;
      REG_COOLDOWN:  return ($urandom_range(0, 1) != 0) ? $urandom_range(200, 900) : $urandom;
      REG_CLAP_EN, REG_SCHED_EN:
        return ($urandom & 32'hFFFF_FFFE) | 32'($urandom_range(0, 4) != 0);
      REG_ON_TIME, REG_OFF_TIME:
        return ($urandom_range(0, 1) != 0) ? $urandom_range(0, 1439) : $urandom;
      default: return $urandom;
    endcase
  endfunction

  task automatic push_item(input in_item_t it, input bit typed, input out_item_t want);
    int unsigned gap;
    out_item_t   res;
    gap = idle_len();
    if (gap != 0) begin
      in_bus.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bus.operation     = it.operation;
    in_bus.sound_level   = it.sound_level;
    in_bus.now_ms        = it.now_ms;
    in_bus.clock_hour    = it.clock_hour;
    in_bus.clock_minute  = it.clock_minute;
    in_bus.day_of_year   = it.day_of_year;
    in_bus.clock_valid   = it.clock_valid;
    in_bus.relay_command = it.relay_command;
    in_bus.valid         = 1'b1;
    @(posedge clk);
    while (in_bus.ready !== 1'b1) @(posedge clk);
    // transfer at this edge
    res = relay_next(it);
    status_due.push_back(typed ? want : res);
    @(negedge clk);
  endtask

  // Drop valid and let every pending status come back before touching registers
  task automatic settle();
    in_bus.valid = 1'b0;
    while (status_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = {idx, 2'b00};
    cfg_pwdata  = data;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    while (cfg_pready !== 1'b1) @(posedge clk);
    apply_reg(idx, data);
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
  endtask

  initial begin
    int unsigned gap;
    out_bus.ready = 1'b0;
    forever begin
      gap = idle_len();
      if (gap != 0) begin
        out_bus.ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_bus.ready = 1'b1;
      @(posedge clk);
      while (out_bus.valid !== 1'b1) @(posedge clk);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin : score
    out_item_t seen;
    out_item_t want;
    if (rst_n === 1'b1 && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
      seen.relay_on       = out_bus.relay_on;
      seen.sound_active   = out_bus.sound_active;
      seen.peak_level     = out_bus.peak_level;
      seen.clap_count     = out_bus.clap_count;
      seen.clap_triggered = out_bus.clap_triggered;
      if (status_due.size() == 0) begin
        fails = fails + 1;
        if (fails <= 10) $display("status transfer with nothing pending");
      end else begin
        want = status_due.pop_front();
        if (seen !== want) begin
          fails = fails + 1;
          if (fails <= 10)
            $display("status mismatch: expected relay=%0b active=%0b peak=%0d claps=%0d trig=%0b, %s",
                     want.relay_on, want.sound_active, want.peak_level, want.clap_count,
                     want.clap_triggered,
                     $sformatf("got relay=%0b active=%0b peak=%0d claps=%0d trig=%0b",
                               seen.relay_on, seen.sound_active, seen.peak_level,
                               seen.clap_count, seen.clap_triggered));
        end
      end
    end
  end

  initial begin
    int unsigned mode;
    fails       = 0;
    cycle_count = 0;
    steady      = 1'b0;
    in_burst    = 1'b0;
    clock_ms    = 32'd10000;
    rst_n       = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    in_bus.valid         = 1'b0;
    in_bus.operation     = '0;
    in_bus.sound_level   = '0;
    in_bus.now_ms        = '0;
    in_bus.clock_hour    = '0;
    in_bus.clock_minute  = '0;
    in_bus.day_of_year   = '0;
    in_bus.clock_valid   = 1'b0;
    in_bus.relay_command = '0;
    reset_model();
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    plan.push_back(known(op_row(OP_RELAY, CMD_ON), 1'b1, 1'b0, '0, '0, 1'b0));
    plan.push_back(known(sound_row(LEVEL_MAX, 32'd1000), 1'b1, 1'b1, LEVEL_MAX, '0, 1'b0));
    plan.push_back(known(sound_row(LEVEL_MAX, 32'd1005), 1'b0, 1'b1, 12'd4094, 32'd1, 1'b1));
    plan.push_back(sound_row(LEVEL_MAX, 32'd3000));        // disarmed until quiet
    plan.push_back(sound_row('0, 32'd3001));
    plan.push_back(sound_row(THRESHOLD_RST, 32'd3010));    // level equal to threshold
    plan.push_back(sound_row(THRESHOLD_RST, 32'd3015));
    plan.push_back(sound_row(THRESHOLD_RST - 12'd1, 32'd3016));
    plan.push_back(sound_row(LEVEL_MAX, 32'hFFFF_FFFE));   // hold spans the timestamp wrap
    plan.push_back(sound_row(LEVEL_MAX, 32'd3));
    plan.push_back(op_row(OP_RELAY, CMD_TOGGLE));
    plan.push_back(op_row(OP_RELAY, CMD_SPARE));
    plan.push_back(op_row(OP_SPARE, CMD_TOGGLE));
    plan.push_back(sched_row(5'd18, 6'd0, 9'd10, 1'b1));   // schedule still disabled
    plan.push_back(write_row(REG_SCHED_EN, 32'd1));
    plan.push_back(op_row(OP_RELAY, CMD_OFF));
    plan.push_back(sched_row(5'd18, 6'd0, 9'd10, 1'b1));
    plan.push_back(sched_row(5'd6, 6'd0, 9'd10, 1'b1));    // same minute, other hour: skipped
    plan.push_back(op_row(OP_RELAY, CMD_OFF));
    plan.push_back(sched_row(5'd18, 6'd0, 9'd10, 1'b1));   // throttled
    plan.push_back(sched_row(5'd18, 6'd0, 9'd11, 1'b1));
    plan.push_back(sched_row(5'd6, 6'd0, 9'd12, 1'b0));    // clock not valid
    plan.push_back(sched_row(5'd6, 6'd0, 9'd12, 1'b1));
    plan.push_back(sched_row(5'd31, 6'd63, 9'd511, 1'b1)); // out of range clock
    plan.push_back(write_row(REG_ON_TIME, '1));
    plan.push_back(sched_row(5'd23, 6'd59, 9'd12, 1'b1));
    plan.push_back(write_row(REG_OFF_TIME, '0));
    plan.push_back(sched_row(5'd0, 6'd0, 9'd365, 1'b1));
    plan.push_back(write_row(REG_THRESHOLD, '0));
    plan.push_back(sound_row(THRESHOLD_LO, 32'd5000));

    foreach (plan[i]) begin
      if (plan[i].is_write) begin
        settle();
        write_reg(plan[i].reg_idx, plan[i].reg_data);
      end else begin
        push_item(plan[i].item, plan[i].typed, plan[i].want);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      mode   = (ph < 2) ? ph : 2;
      steady = (ph % 4 == 2);
      settle();
      for (int r = 0; r <= int'(REG_SPARE); r++)
        write_reg(REG_IDX_W'(r), cfg_pick(REG_IDX_W'(r), mode));
      // push some phases across the timestamp wrap
      if ($urandom_range(0, 2) == 0) clock_ms = 32'hFFFF_FFFF - MS_W'($urandom_range(0, 3000));
      for (int n = 0; n < PHASE_ITEMS; n++) push_item(rand_item(), 1'b0, '0);
    end

    settle();
    repeat (8) @(negedge clk);
    if (fails == 0 && status_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> clap_and_schedule_relay_control_core.f
src/cscr_pkg.sv
src/cscr_if.sv
src/cscr_cfg.sv
src/cscr_step.sv
src/clap_and_schedule_relay_control_core.sv
dv/tb_clap_and_schedule_relay_control_core.sv
